@@ design/upn_pkg.sv @@
// shared types, constants and helpers for the uri path normalizer
package upn_pkg;

  localparam int CH_W      = 8;
  localparam int CAP_W     = 13;
  localparam int LEN_W     = 12;
  localparam int KIND_W    = 2;
  localparam int TDATA_OUT_W = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd513;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  localparam logic [CH_W-1:0] CH_END      = 8'h00;
  localparam logic [CH_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [CH_W-1:0] CH_HASH     = 8'h23;
  localparam logic [CH_W-1:0] CH_PERCENT  = 8'h25;
  localparam logic [CH_W-1:0] CH_SLASH    = 8'h2F;
  localparam logic [CH_W-1:0] CH_DOT      = 8'h2E;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC_HI,
    MODE_ESC_LO,
    MODE_SKIP,
    MODE_DRAIN
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   path_byte;
    logic [LEN_W-1:0]  path_length;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [CH_W-1:0] b);
    logic [4:0] res;
    res = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      res = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      res = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      res = {1'b1, 4'(b - 8'h37)};
    end
    return res;
  endfunction

endpackage

@@ design/uri_path_normalizer_unit.sv @@
// uri path normalizer top level
//
// Raw URI bytes come in on the s_ stream, one byte per item; a zero byte
// ends a URI. Decoded path bytes and one end item per URI (accepted or
// rejected, with the path length) leave on the m_ stream; m_tlast marks the
// end item and m_tuser gives its kind. The out_capacity register must be written
// through cfg_we/cfg_wdata only while the stream is idle; the block does not enforce this.
// An item accepted into the input register is parsed from it in the next cycle;
// its results are written into the result queue and then show on m_tvalid.
// Throughput: one input item per cycle while s_tready is high; the parse stage produces up to two
// results per item into an eight-entry result queue that drains one per cycle while m_tready is high.
// Only the end byte of a URI with an empty path yields two results.
// s_tready drops when the queue could not take two more results for both the
// item in the parse stage and a new one; a stalled receiver therefore backs
// up into the input side and nothing is dropped.
// Reset clears the parse state, empties the queue and sets out_capacity to
// 513; s_tready is high in the first cycle after reset.
module uri_path_normalizer_unit #(
  parameter int MAX_CAPACITY = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [upn_pkg::CH_W-1:0]           s_tdata,   // ch
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [upn_pkg::TDATA_OUT_W-1:0]    m_tdata,   // path_byte, path_length, pad
  output logic [upn_pkg::KIND_W-1:0]         m_tuser,   // kind
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [upn_pkg::CAP_W-1:0]          cfg_wdata
);

  upn_pkg::push_t                  push;
  upn_pkg::result_t                head;
  logic                            busy;
  logic                            in_take;
  logic [upn_pkg::FIFO_CNT_W-1:0]  count;
  logic [upn_pkg::FIFO_CNT_W:0]    committed;

  assign committed = {1'b0, count} + {{(upn_pkg::FIFO_CNT_W - 1){1'b0}}, busy, 1'b0};
  assign s_tready  = (committed <= (upn_pkg::FIFO_CNT_W + 1)'(upn_pkg::FIFO_DEPTH - 2));
  assign in_take   = s_tvalid && s_tready;

  upn_core #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_ch     (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .push      (push)
  );

  upn_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .not_empty (m_tvalid),
    .head      (head),
    .count     (count)
  );

  assign m_tdata = {4'd0, head.path_length, head.path_byte};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

@@ design/upn_core.sv @@
// input register, parse state and per-item result logic
module upn_core #(
  parameter int MAX_CAPACITY = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_take,
  input  logic [upn_pkg::CH_W-1:0]     in_ch,
  input  logic                         cfg_we,
  input  logic [upn_pkg::CAP_W-1:0]    cfg_wdata,
  output logic                         busy,
  output upn_pkg::push_t               push
);

  localparam int CNT_W = $clog2(MAX_CAPACITY);
  localparam int CMP_W = ((CNT_W > upn_pkg::CAP_W) ? CNT_W : upn_pkg::CAP_W) + 2;

  logic                        valid_q;
  logic [upn_pkg::CH_W-1:0]    ch_q;
  logic [upn_pkg::CAP_W-1:0]   out_capacity;

  upn_pkg::mode_t              mode, mode_next;
  logic [3:0]                  high_nibble, high_nibble_next;
  logic [CNT_W-1:0]            out_count, out_count_next;
  logic [upn_pkg::CH_W-1:0]    last_out_byte, last_out_byte_next;
  logic [1:0]                  segment_length, segment_length_next;

  logic [CMP_W-1:0]            cap_u;
  logic [4:0]                  hx;
  logic                        do_take;
  logic [upn_pkg::CH_W-1:0]    take_c;
  logic [upn_pkg::LEN_W-1:0]   len_now;
  upn_pkg::push_t              res;

  assign busy = valid_q;
  assign hx = upn_pkg::hex_nibble(ch_q);
  assign len_now = upn_pkg::LEN_W'(out_count);
  assign cap_u = (CMP_W'(out_capacity) > CMP_W'(MAX_CAPACITY)) ?
                 CMP_W'(MAX_CAPACITY) : CMP_W'(out_capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q        <= 1'b0;
      out_capacity   <= upn_pkg::CAP_RESET;
      mode           <= upn_pkg::MODE_NORMAL;
      high_nibble    <= '0;
      out_count      <= '0;
      last_out_byte  <= '0;
      segment_length <= '0;
    end else begin
      valid_q <= in_take;
      if (cfg_we) begin
        out_capacity <= cfg_wdata;
      end
      if (valid_q) begin
        mode           <= mode_next;
        high_nibble    <= high_nibble_next;
        out_count      <= out_count_next;
        last_out_byte  <= last_out_byte_next;
        segment_length <= segment_length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_q <= in_ch;
    end
  end

  always_comb begin
    mode_next           = mode;
    high_nibble_next    = high_nibble;
    out_count_next      = out_count;
    last_out_byte_next  = last_out_byte;
    segment_length_next = segment_length;
    do_take             = 1'b0;
    take_c              = ch_q;
    res                 = '0;

    case (mode)
      upn_pkg::MODE_ESC_HI, upn_pkg::MODE_ESC_LO: begin
        if (ch_q == upn_pkg::CH_END) begin
          res.n  = 2'd1;
          res.r0 = '{upn_pkg::KIND_REJECT, 8'd0, len_now, 1'b1};
        end else if (!hx[4]) begin
          mode_next = upn_pkg::MODE_DRAIN;
        end else if (mode == upn_pkg::MODE_ESC_HI) begin
          high_nibble_next = hx[3:0];
          mode_next        = upn_pkg::MODE_ESC_LO;
        end else begin
          mode_next = upn_pkg::MODE_NORMAL;
          do_take   = 1'b1;
          take_c    = {high_nibble, hx[3:0]};
        end
      end
      upn_pkg::MODE_DRAIN: begin
        if (ch_q == upn_pkg::CH_END) begin
          res.n  = 2'd1;
          res.r0 = '{upn_pkg::KIND_REJECT, 8'd0, len_now, 1'b1};
        end
      end
      default: begin
        if (ch_q == upn_pkg::CH_END) begin
          if (out_count != '0) begin
            res.n  = 2'd1;
            res.r0 = '{upn_pkg::KIND_ACCEPT, 8'd0, len_now, 1'b1};
          end else if (cap_u < CMP_W'(2)) begin
            res.n  = 2'd1;
            res.r0 = '{upn_pkg::KIND_REJECT, 8'd0, len_now, 1'b1};
          end else begin
            res.n  = 2'd2;
            res.r0 = '{upn_pkg::KIND_BYTE, upn_pkg::CH_SLASH,
                       upn_pkg::LEN_W'(1), 1'b0};
            res.r1 = '{upn_pkg::KIND_ACCEPT, 8'd0, upn_pkg::LEN_W'(1), 1'b1};
          end
        end else if (mode == upn_pkg::MODE_SKIP) begin
          mode_next = upn_pkg::MODE_SKIP;
        end else if (ch_q == upn_pkg::CH_QUESTION || ch_q == upn_pkg::CH_HASH) begin
          mode_next = upn_pkg::MODE_SKIP;
        end else if (ch_q == upn_pkg::CH_PERCENT) begin
          mode_next = upn_pkg::MODE_ESC_HI;
        end else begin
          do_take = 1'b1;
        end
      end
    endcase

    if (do_take) begin
      if (CMP_W'(out_count) + CMP_W'(1) >= cap_u) begin
        mode_next = upn_pkg::MODE_DRAIN;
      end else if (take_c == upn_pkg::CH_SLASH &&
                   out_count != '0 && last_out_byte == upn_pkg::CH_SLASH) begin
        mode_next = mode_next;
      end else if (take_c != upn_pkg::CH_SLASH && segment_length == 2'd1 &&
                   last_out_byte == upn_pkg::CH_DOT && take_c == upn_pkg::CH_DOT) begin
        mode_next = upn_pkg::MODE_DRAIN;
      end else begin
        if (take_c == upn_pkg::CH_SLASH) begin
          segment_length_next = 2'd0;
        end else if (segment_length < 2'd2) begin
          segment_length_next = segment_length + 2'd1;
        end
        out_count_next     = out_count + CNT_W'(1);
        last_out_byte_next = take_c;
        res.n  = 2'd1;
        res.r0 = '{upn_pkg::KIND_BYTE, take_c,
                   upn_pkg::LEN_W'(out_count + CNT_W'(1)), 1'b0};
      end
    end

    // an end result returns the uri state to its reset values
    if (res.n != 2'd0 && ((res.n == 2'd1) ? res.r0.last : res.r1.last)) begin
      mode_next           = upn_pkg::MODE_NORMAL;
      high_nibble_next    = '0;
      out_count_next      = '0;
      last_out_byte_next  = '0;
      segment_length_next = '0;
    end
  end

  always_comb begin
    push = res;
    if (!valid_q) begin
      push.n = 2'd0;
    end
  end

endmodule

@@ design/upn_fifo.sv @@
// result queue taking up to two items per cycle and giving one per cycle when popped
module upn_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  upn_pkg::push_t                  push,
  input  logic                            pop,
  output logic                            not_empty,
  output upn_pkg::result_t                head,
  output logic [upn_pkg::FIFO_CNT_W-1:0]  count
);

  upn_pkg::result_t                 mem [upn_pkg::FIFO_DEPTH];
  logic [upn_pkg::FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [upn_pkg::FIFO_PTR_W-1:0]   wr_ptr_1;

  assign wr_ptr_1  = wr_ptr + upn_pkg::FIFO_PTR_W'(1);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + upn_pkg::FIFO_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + upn_pkg::FIFO_PTR_W'(1);
      end
      count <= count + upn_pkg::FIFO_CNT_W'(push.n) - upn_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_1] <= push.r1;
    end
  end

endmodule

@@ design/upn_checker.sv @@
// port-level checks for the uri path normalizer
module upn_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [upn_pkg::TDATA_OUT_W-1:0]  m_tdata,
  input logic [upn_pkg::KIND_W-1:0]       m_tuser,
  input logic                             m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != upn_pkg::KIND_BYTE)))
    else $error("tlast does not match item kind");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == upn_pkg::KIND_BYTE || m_tuser == upn_pkg::KIND_ACCEPT
      || m_tuser == upn_pkg::KIND_REJECT))
    else $error("unknown item kind");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[7:0] == 8'd0) && (m_tdata[23:20] == 4'd0))
    else $error("end item carries a path byte");

  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind uri_path_normalizer_unit upn_checker u_upn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
